### rtl/core/ert_pkg.sv
// Package of the expiring registration table.
// Holds field widths, request and status codes and the sequencer state type.
// Used by every other file of the block but ert_table_mem; depends on nothing.
`timescale 1ns / 1ps

package ert_pkg;

	localparam int REQ_W    = 2;
	localparam int KEY_W    = 32;
	localparam int NOW_W    = 64;
	localparam int LIFE_W   = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 10;
	localparam int CNT_W    = 11;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CNT_W-1:0] COUNT_LOW   = CNT_W'(32);
	localparam logic [CNT_W-1:0] COUNT_HIGH  = CNT_W'(1024);
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

	// Register index as decoded from paddr[2].
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ert_state_t;

endpackage

### rtl/core/ert_ifs.sv
// Request and response channel interfaces of the expiring registration table.
// Depends on ert_pkg for the field widths.
`timescale 1ns / 1ps

interface ert_req_if;
	import ert_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [KEY_W-1:0]    from_tag_key;
	logic [KEY_W-1:0]    call_id_key;
	logic [NOW_W-1:0]    now;
	logic [LIFE_W-1:0]   life_ms;

	modport source (
		output valid, req_type, from_tag_key, call_id_key, now, life_ms,
		input  ready
	);
	modport sink (
		input  valid, req_type, from_tag_key, call_id_key, now, life_ms,
		output ready
	);
endinterface

interface ert_rsp_if;
	import ert_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [CNT_W-1:0]    freed_count;

	modport source (
		output valid, status, slot_index, freed_count,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, freed_count,
		output ready
	);
endinterface

### rtl/core/ert_table_mem.sv
// Slot table memory: one write port and one read port, read data registered.
// Generic storage; depends on nothing.
`timescale 1ns / 1ps

module ert_table_mem #(
	parameter int DEPTH  = 1024,
	parameter int IDX_W  = 10,
	parameter int WORD_W = 161
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/ert_scan.sv
// Request sequencer: clears the table after reset, then walks the slots one
// per cycle for add, lookup and tick. Depends on ert_pkg and ert_ifs.
`timescale 1ns / 1ps

module ert_scan #(
	parameter int DEPTH  = 1024,
	parameter int KEY_W  = 32,
	parameter int IDX_W  = $clog2(DEPTH),
	parameter int WORD_W = 1 + 2 * KEY_W + ert_pkg::NOW_W + ert_pkg::LIFE_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ert_pkg::CNT_W-1:0] active_count,
	ert_req_if.sink                  req,
	ert_rsp_if.source                rsp,
	output logic                     mem_wr_en,
	output logic [IDX_W-1:0]         mem_wr_addr,
	output logic [WORD_W-1:0]        mem_wr_data,
	output logic                     mem_rd_en,
	output logic [IDX_W-1:0]         mem_rd_addr,
	input  logic [WORD_W-1:0]        mem_rd_data
);
	import ert_pkg::*;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  tag;
		logic [KEY_W-1:0]  call;
		logic [NOW_W-1:0]  birth;
		logic [LIFE_W-1:0] life;
	} slot_word_t;

	ert_state_t state_q, state_d;

	logic [IDX_W-1:0]    clr_q;
	logic [CNT_W-1:0]    ctr_q;
	logic [CNT_W-1:0]    n_q;
	logic [REQ_W-1:0]    req_type_q;
	logic [KEY_W-1:0]    tag_q;
	logic [KEY_W-1:0]    call_q;
	logic [NOW_W-1:0]    now_q;
	logic [LIFE_W-1:0]   life_q;
	logic                eval_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [CNT_W-1:0]    freed_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_slot_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [CNT_W-1:0]    out_freed_q;

	slot_word_t        rd_word;
	slot_word_t        wr_word;
	logic [NOW_W:0]    expiry;
	logic              is_free;
	logic              is_match;
	logic              is_expired;
	logic              scan_more;
	logic              scan_hit;
	logic              expire_now;
	logic              accept;
	logic              known_req;
	logic              rsp_load;

	assign rd_word    = slot_word_t'(mem_rd_data);
	assign expiry     = {1'b0, rd_word.birth} + {(NOW_W - LIFE_W + 1)'(0), rd_word.life};
	assign is_free    = !rd_word.valid;
	assign is_match   = rd_word.valid && (rd_word.tag == tag_q) && (rd_word.call == call_q);
	assign is_expired = rd_word.valid && (expiry < {1'b0, now_q});
	assign scan_more  = ctr_q < n_q;
	assign known_req  = (req.req_type == REQ_ADD) || (req.req_type == REQ_LOOKUP)
		|| (req.req_type == REQ_TICK);
	assign accept     = req.valid && req.ready;

	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_s1;
		wr_word     = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ctr_q[IDX_W-1:0];
		scan_hit    = 1'b0;
		expire_now  = 1'b0;
		rsp_load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
				if (clr_q == IDX_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = known_req ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				mem_rd_en = scan_more;
				if (eval_s1) begin
					case (req_type_q)
						REQ_ADD: begin
							if (is_free) begin
								scan_hit  = 1'b1;
								mem_wr_en = 1'b1;
								wr_word   = '{valid: 1'b1, tag: tag_q, call: call_q,
									birth: now_q, life: life_q};
							end
						end
						REQ_LOOKUP: begin
							scan_hit = is_match;
						end
						REQ_TICK: begin
							if (is_expired) begin
								expire_now = 1'b1;
								mem_wr_en  = 1'b1;
								wr_word    = '{valid: 1'b0, tag: rd_word.tag,
									call: rd_word.call, birth: '0, life: '0};
							end
						end
						default: begin
						end
					endcase
				end
				if (scan_hit || (!eval_s1 && !scan_more)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		mem_wr_data = WORD_W'(wr_word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ctr_q       <= '0;
			eval_s1     <= 1'b0;
			freed_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (accept) begin
				ctr_q   <= '0;
				freed_q <= '0;
			end else if (mem_rd_en) begin
				ctr_q <= ctr_q + CNT_W'(1);
			end
			if (expire_now) begin
				freed_q <= freed_q + CNT_W'(1);
			end
			eval_s1 <= mem_rd_en;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= mem_rd_addr;
		if (accept) begin
			n_q        <= active_count;
			req_type_q <= req.req_type;
			tag_q      <= req.from_tag_key[KEY_W-1:0];
			call_q     <= req.call_id_key[KEY_W-1:0];
			now_q      <= req.now;
			life_q     <= req.life_ms;
			res_slot_q <= '0;
			case (req.req_type)
				REQ_ADD:  res_status_q <= STAT_FULL;
				REQ_TICK: res_status_q <= STAT_DONE;
				default:  res_status_q <= STAT_MISS;
			endcase
		end else if (scan_hit) begin
			res_status_q <= STAT_DONE;
			res_slot_q   <= idx_s1;
		end
		if (rsp_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= SLOT_W'(res_slot_q);
			out_freed_q  <= (req_type_q == REQ_TICK) ? freed_q : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot_index  = out_slot_q;
	assign rsp.freed_count = out_freed_q;

endmodule

### rtl/core/expiring_registration_table.sv
// Expiring registration table: APB register, slot memory and request sequencer.
// Add stops at the first free slot and lookup at the first match; a walk that
// finds neither, and a tick, covers all n active slots (n is the active slot
// count). An unknown request skips the walk; one request is served at a time.
// After reset the table memory is cleared, all MAX_SLOTS slots (at most 1024).
`timescale 1ns / 1ps

module expiring_registration_table #(
	parameter int MAX_SLOTS = 1024,
	parameter int KEY_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ert_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ert_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ert_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	ert_req_if.sink                        req,
	ert_rsp_if.source                      rsp
);
	import ert_pkg::*;

	localparam int Depth  = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;
	localparam int IdxW   = $clog2(Depth);
	localparam int KeyW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int WordW  = 1 + 2 * KeyW + NOW_W + LIFE_W;
	localparam logic [CNT_W-1:0] CountMax = CNT_W'(Depth);

	logic [CNT_W-1:0]  slots_in_use_q;
	logic [CNT_W-1:0]  active_count;
	logic              mem_wr_en;
	logic [IdxW-1:0]   mem_wr_addr;
	logic [WordW-1:0]  mem_wr_data;
	logic              mem_rd_en;
	logic [IdxW-1:0]   mem_rd_addr;
	logic [WordW-1:0]  mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS_IN_USE)) begin
			slots_in_use_q <= pwdata[CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? APB_DATA_W'(slots_in_use_q) : '0;

	always_comb begin
		if (slots_in_use_q < COUNT_LOW) begin
			active_count = COUNT_LOW;
		end else if (slots_in_use_q > CountMax) begin
			active_count = CountMax;
		end else begin
			active_count = slots_in_use_q;
		end
	end

	ert_table_mem #(
		.DEPTH  (Depth),
		.IDX_W  (IdxW),
		.WORD_W (WordW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	ert_scan #(
		.DEPTH  (Depth),
		.KEY_W  (KeyW),
		.IDX_W  (IdxW),
		.WORD_W (WordW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.active_count (active_count),
		.req          (req),
		.rsp          (rsp),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

endmodule

### rtl/core/ert_checker.sv
// Port-level checker of the expiring registration table and its bind.
// Depends on ert_pkg and ert_ifs.
`timescale 1ns / 1ps

module ert_checker (
	input logic       clk,
	input logic       arst_n,
	ert_req_if.sink   req,
	ert_rsp_if.source rsp
);
	import ert_pkg::*;

	// Requests are served one at a time, so two transfers never come back to back.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request transfer in two consecutive cycles");

	a_miss_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_DONE) |->
		(rsp.slot_index == '0 && rsp.freed_count == '0))
		else $error("full or miss result carries a slot or a freed count");

	a_freed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.freed_count <= COUNT_HIGH))
		else $error("freed count beyond the table size");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status)
		&& $stable(rsp.slot_index) && $stable(rsp.freed_count)))
		else $error("stalled result changed");

endmodule

bind expiring_registration_table ert_checker u_ert_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
